FILE: rtl/mmcal_pkg.sv
// ----------------------------------------------------------------------------
// mmcal_pkg
// shared constants and request codes for the magnetometer min/max calibration
// ----------------------------------------------------------------------------
package mmcal_pkg;

    // request codes carried in req_type
    localparam logic [1:0] REQ_RESTART  = 2'd0;
    localparam logic [1:0] REQ_COLLECT  = 2'd1;
    localparam logic [1:0] REQ_FINALIZE = 2'd2;
    localparam logic [1:0] REQ_CORRECT  = 2'd3;

    localparam int REQ_W   = 2;
    localparam int AXES    = 3;
    localparam int AX_W    = 2;
    localparam int SCALE_W = 32;
    localparam int OUT_W   = 24;
    localparam int COL_W   = 16;

    localparam int OUT_MAX = 8388607;
    localparam int OUT_MIN = -8388608;
    localparam int COL_MAX = 65535;

endpackage

FILE: rtl/mmcal_if.sv
// ----------------------------------------------------------------------------
// mmcal_if
// request and result channels of the magnetometer min/max calibration
// ----------------------------------------------------------------------------
interface mmcal_req_if #(
    parameter int SAMPLE_BITS = 16
);
    import mmcal_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [REQ_W-1:0]              req_type;
    logic signed [SAMPLE_BITS-1:0] sample_x;
    logic signed [SAMPLE_BITS-1:0] sample_y;
    logic signed [SAMPLE_BITS-1:0] sample_z;

    modport source (
        output valid, req_type, sample_x, sample_y, sample_z,
        input  ready
    );

    modport sink (
        input  valid, req_type, sample_x, sample_y, sample_z,
        output ready
    );
endinterface

interface mmcal_res_if;
    import mmcal_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] out_x;
    logic signed [OUT_W-1:0] out_y;
    logic signed [OUT_W-1:0] out_z;
    logic                    calibrated;
    logic [COL_W-1:0]        collected;
    logic                    no_samples;

    modport source (
        output valid, out_x, out_y, out_z, calibrated, collected, no_samples,
        input  ready
    );

    modport sink (
        input  valid, out_x, out_y, out_z, calibrated, collected, no_samples,
        output ready
    );
endinterface

FILE: rtl/magnetometer_minmax_calibration.sv
// ----------------------------------------------------------------------------
// magnetometer_minmax_calibration
// hard/soft iron min/max calibration with one shared divider and one shared correction multiplier
// ----------------------------------------------------------------------------
// The block takes one request at a time and answers each with exactly one
// result transfer. Collect and restart update the state, then load the result
// register once it is free. Correct runs the three axes through one multiplier,
// each axis passing a multiply state and then a saturate state. Finalize uses
// the shared restoring divider, which retires one quotient bit per cycle over
// DW = SAMPLE_BITS + SCALE_FRAC_BITS + 1 bits. The mean span (sum + 1) / 3
// comes from a reciprocal multiply, then each axis with a nonzero span takes
// one division; a flat axis keeps unit gain without one.
// A finalize with no collected samples answers at once with no_samples set.
// The request side is ready whenever the sequencer is idle; a finished result
// sits in the output register while the next request is already taken.
module magnetometer_minmax_calibration #(
    parameter int SAMPLE_BITS     = 16,
    parameter int SCALE_FRAC_BITS = 16,
    parameter int COUNT_BITS      = 16
) (
    input logic         clk,
    input logic         rst_n,
    mmcal_req_if.sink   req,
    mmcal_res_if.source res
);
    import mmcal_pkg::*;

    localparam int SW = SAMPLE_BITS;
    localparam int DW = SAMPLE_BITS + SCALE_FRAC_BITS + 1;  // divider width
    localparam int CW = $clog2(DW + 1);                      // divider step counter width
    localparam int PW = SAMPLE_BITS + SCALE_W + 2;           // product width

    localparam logic signed [SW-1:0] SMP_MAX   = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMP_MIN   = {1'b1, {(SW-1){1'b0}}};
    localparam logic [SCALE_W-1:0]   SCALE_ONE = SCALE_W'(64'd1 << SCALE_FRAC_BITS);
    localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};
    localparam logic [DW-1:0]        QUO_MAX   = DW'(64'hFFFF_FFFF);
    localparam logic signed [PW-1:0] OUT_HI    = PW'(OUT_MAX);
    localparam logic signed [PW-1:0] OUT_LO    = PW'(OUT_MIN);
    localparam logic [AX_W-1:0]      AX_LAST   = AX_W'(AXES - 1);
    // reciprocal of three, exact over the whole span sum range
    localparam logic [SW+1:0]        MEAN_MUL  =
        (SW+2)'(((64'd1 << (SW + 3)) + 64'd2) / 64'd3);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEAN,
        ST_DIV,
        ST_DIV_END,
        ST_AXIS,
        ST_MUL,
        ST_SAT,
        ST_RESP
    } state_t;

    // max - min, never negative once a sample has been collected
    function automatic logic [SW-1:0] span_of(input logic signed [SW-1:0] hi,
                                               input logic signed [SW-1:0] lo);
        logic signed [SW:0] d;
        d = {hi[SW-1], hi} - {lo[SW-1], lo};
        return d[SW-1:0];
    endfunction

    // floor((max + min) / 2)
    function automatic logic signed [SW-1:0] mid_of(input logic signed [SW-1:0] hi,
                                                    input logic signed [SW-1:0] lo);
        logic signed [SW:0] s;
        s = {hi[SW-1], hi} + {lo[SW-1], lo};
        return s[SW:1];
    endfunction

    state_t state_reg, state_next;

    // calibration state
    logic signed [SW-1:0]      min_reg [AXES];
    logic signed [SW-1:0]      min_next [AXES];
    logic signed [SW-1:0]      max_reg [AXES];
    logic signed [SW-1:0]      max_next [AXES];
    logic signed [SW-1:0]      off_reg [AXES];
    logic signed [SW-1:0]      off_next [AXES];
    logic [SCALE_W-1:0]        scale_reg [AXES];
    logic [SCALE_W-1:0]        scale_next [AXES];
    logic [COUNT_BITS-1:0]     total_reg, total_next;
    logic                      done_reg, done_next;

    // per-request working registers
    logic signed [SW-1:0]      smp_reg [AXES];
    logic signed [SW-1:0]      smp_next [AXES];
    logic signed [OUT_W-1:0]   acc_reg [AXES];
    logic signed [OUT_W-1:0]   acc_next [AXES];
    logic                      nos_reg, nos_next;
    logic [AX_W-1:0]           ax_reg, ax_next;
    logic [SW-1:0]             mean_reg, mean_next;
    logic signed [PW-1:0]      prod_reg, prod_next;

    // shared divider
    logic [SW-1:0]             rem_reg, rem_next;
    logic [DW-1:0]             qr_reg, qr_next;
    logic [SW-1:0]             dsr_reg, dsr_next;
    logic [CW-1:0]             cnt_reg, cnt_next;

    // result register
    logic                      ovalid_reg, ovalid_next;
    logic signed [OUT_W-1:0]   ox_reg, ox_next;
    logic signed [OUT_W-1:0]   oy_reg, oy_next;
    logic signed [OUT_W-1:0]   oz_reg, oz_next;
    logic                      ocal_reg, ocal_next;
    logic [COL_W-1:0]          ocol_reg, ocol_next;
    logic                      onos_reg, onos_next;

    // datapath helpers
    logic [SW:0]               div_trial;
    logic                      div_ge;
    logic [SW:0]               div_diff;
    logic [SW-1:0]             span_sel;
    logic [SW+1:0]             span_sum;
    logic [2*SW+3:0]           mean_prod;
    logic signed [SW:0]        mul_diff;
    logic signed [SCALE_W:0]   mul_scale;
    logic signed [PW-1:0]      sat_q;
    logic signed [OUT_W-1:0]   sat_out;
    logic [SCALE_W-1:0]        quo_sat;
    logic signed [SW-1:0]      in_smp [AXES];

    assign in_smp[0] = SW'(req.sample_x);
    assign in_smp[1] = SW'(req.sample_y);
    assign in_smp[2] = SW'(req.sample_z);

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign div_trial = {rem_reg, qr_reg[DW-1]};
    assign div_ge    = div_trial >= {1'b0, dsr_reg};
    assign div_diff  = div_trial - {1'b0, dsr_reg};

    assign quo_sat = (qr_reg > QUO_MAX) ? {SCALE_W{1'b1}} : SCALE_W'(qr_reg);

    assign span_sel = span_of(max_reg[ax_reg], min_reg[ax_reg]);
    assign span_sum = (SW+2)'(span_of(max_reg[0], min_reg[0]))
                    + (SW+2)'(span_of(max_reg[1], min_reg[1]))
                    + (SW+2)'(span_of(max_reg[2], min_reg[2]))
                    + (SW+2)'(1);

    // mean span: registered (sum + 1) times the reciprocal of three
    assign mean_prod = (2*SW+4)'(qr_reg[SW+1:0]) * (2*SW+4)'(MEAN_MUL);

    // correction: one axis through the multiplier per pass
    assign mul_diff  = {smp_reg[ax_reg][SW-1], smp_reg[ax_reg]}
                     - {off_reg[ax_reg][SW-1], off_reg[ax_reg]};
    assign mul_scale = $signed({1'b0, scale_reg[ax_reg]});

    // arithmetic shift floors toward minus infinity, then clamp to 24 bits
    assign sat_q = prod_reg >>> SCALE_FRAC_BITS;

    always_comb
    begin
        priority if (sat_q > OUT_HI)
        begin
            sat_out = OUT_HI[OUT_W-1:0];
        end
        else if (sat_q < OUT_LO)
        begin
            sat_out = OUT_LO[OUT_W-1:0];
        end
        else
        begin
            sat_out = sat_q[OUT_W-1:0];
        end
    end

    assign req.ready      = (state_reg == ST_IDLE);
    assign res.valid      = ovalid_reg;
    assign res.out_x      = ox_reg;
    assign res.out_y      = oy_reg;
    assign res.out_z      = oz_reg;
    assign res.calibrated = ocal_reg;
    assign res.collected  = ocol_reg;
    assign res.no_samples = onos_reg;

    always_comb
    begin
        state_next      = state_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        off_next        = off_reg;
        scale_next      = scale_reg;
        total_next      = total_reg;
        done_next       = done_reg;
        smp_next        = smp_reg;
        acc_next        = acc_reg;
        nos_next        = nos_reg;
        ax_next         = ax_reg;
        mean_next       = mean_reg;
        prod_next       = prod_reg;
        rem_next        = rem_reg;
        qr_next         = qr_reg;
        dsr_next        = dsr_reg;
        cnt_next        = cnt_reg;
        ovalid_next     = ovalid_reg;
        ox_next         = ox_reg;
        oy_next         = oy_reg;
        oz_next         = oz_reg;
        ocal_next       = ocal_reg;
        ocol_next       = ocol_reg;
        onos_next       = onos_reg;

        // result transfer frees the output register
        if (ovalid_reg && res.ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    smp_next = in_smp;
                    nos_next = 1'b0;
                    ax_next  = '0;
                    for (int i = 0; i < AXES; i++)
                    begin
                        acc_next[i] = '0;
                    end
                    unique case (req.req_type)
                        REQ_RESTART:
                        begin
                            for (int i = 0; i < AXES; i++)
                            begin
                                min_next[i]   = SMP_MAX;
                                max_next[i]   = SMP_MIN;
                                off_next[i]   = '0;
                                scale_next[i] = SCALE_ONE;
                            end
                            total_next = '0;
                            done_next  = 1'b0;
                            state_next = ST_RESP;
                        end
                        REQ_COLLECT:
                        begin
                            for (int i = 0; i < AXES; i++)
                            begin
                                if (in_smp[i] < min_reg[i])
                                begin
                                    min_next[i] = in_smp[i];
                                end
                                if (in_smp[i] > max_reg[i])
                                begin
                                    max_next[i] = in_smp[i];
                                end
                            end
                            if (total_reg != CNT_MAX)
                            begin
                                total_next = total_reg + COUNT_BITS'(1);
                            end
                            state_next = ST_RESP;
                        end
                        REQ_FINALIZE:
                        begin
                            if (total_reg == '0)
                            begin
                                nos_next   = 1'b1;
                                state_next = ST_RESP;
                            end
                            else
                            begin
                                for (int i = 0; i < AXES; i++)
                                begin
                                    off_next[i] = mid_of(max_reg[i], min_reg[i]);
                                end
                                // hold sum + 1 for the mean span step
                                qr_next    = DW'(span_sum);
                                state_next = ST_MEAN;
                            end
                        end
                        REQ_CORRECT:
                        begin
                            state_next = ST_MUL;
                        end
                    endcase
                end
            end

            ST_MEAN:
            begin
                mean_next  = mean_prod[2*SW+2:SW+3];
                state_next = ST_AXIS;
            end

            ST_DIV:
            begin
                rem_next = div_ge ? div_diff[SW-1:0] : div_trial[SW-1:0];
                qr_next  = {qr_reg[DW-2:0], div_ge};
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    state_next = ST_DIV_END;
                end
            end

            ST_DIV_END:
            begin
                scale_next[ax_reg] = quo_sat;
                if (ax_reg == AX_LAST)
                begin
                    done_next  = 1'b1;
                    state_next = ST_RESP;
                end
                else
                begin
                    ax_next    = ax_reg + AX_W'(1);
                    state_next = ST_AXIS;
                end
            end

            ST_AXIS:
            begin
                if (span_sel == '0)
                begin
                    // flat axis keeps unit gain
                    scale_next[ax_reg] = SCALE_ONE;
                    if (ax_reg == AX_LAST)
                    begin
                        done_next  = 1'b1;
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        ax_next = ax_reg + AX_W'(1);
                    end
                end
                else
                begin
                    // (mean << frac + span / 2) / span rounds to nearest
                    qr_next    = DW'({mean_reg, {SCALE_FRAC_BITS{1'b0}}})
                               + DW'(span_sel >> 1);
                    rem_next   = '0;
                    dsr_next   = span_sel;
                    cnt_next   = CW'(DW);
                    state_next = ST_DIV;
                end
            end

            ST_MUL:
            begin
                prod_next  = PW'(mul_diff) * PW'(mul_scale);
                state_next = ST_SAT;
            end

            ST_SAT:
            begin
                acc_next[ax_reg] = sat_out;
                if (ax_reg == AX_LAST)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    ax_next    = ax_reg + AX_W'(1);
                    state_next = ST_MUL;
                end
            end

            ST_RESP:
            begin
                if (!ovalid_reg || res.ready)
                begin
                    ovalid_next = 1'b1;
                    ox_next     = acc_reg[0];
                    oy_next     = acc_reg[1];
                    oz_next     = acc_reg[2];
                    ocal_next   = done_reg;
                    ocol_next   = (32'(total_reg) > 32'(COL_MAX)) ? {COL_W{1'b1}}
                                                                 : COL_W'(total_reg);
                    onos_next   = nos_reg;
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            for (int i = 0; i < AXES; i++)
            begin
                min_reg[i]   <= SMP_MAX;
                max_reg[i]   <= SMP_MIN;
                off_reg[i]   <= '0;
                scale_reg[i] <= SCALE_ONE;
            end
            total_reg      <= '0;
            done_reg       <= 1'b0;
            nos_reg        <= 1'b0;
            ax_reg         <= '0;
            cnt_reg        <= '0;
            ovalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            min_reg        <= min_next;
            max_reg        <= max_next;
            off_reg        <= off_next;
            scale_reg      <= scale_next;
            total_reg      <= total_next;
            done_reg       <= done_next;
            nos_reg        <= nos_next;
            ax_reg         <= ax_next;
            cnt_reg        <= cnt_next;
            ovalid_reg     <= ovalid_next;
        end
    end

    // datapath payload, no reset needed
    always_ff @(posedge clk)
    begin
        smp_reg  <= smp_next;
        acc_reg  <= acc_next;
        mean_reg <= mean_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        qr_reg   <= qr_next;
        dsr_reg  <= dsr_next;
        ox_reg   <= ox_next;
        oy_reg   <= oy_next;
        oz_reg   <= oz_next;
        ocal_reg <= ocal_next;
        ocol_reg <= ocol_next;
        onos_reg <= onos_next;
    end

endmodule

FILE: dv/magnetometer_minmax_calibration_tb.sv
// ----------------------------------------------------------------------------
// magnetometer_minmax_calibration_tb
// self-checking bench for the min/max hard/soft iron calibration block
// ----------------------------------------------------------------------------
// A directed table covers the extremes, restart and the finalize corner cases.
// Random restart/collect/finalize/correct sequences follow, mixed with noise.
// Every result transfer is checked field by field against a typed-in result
// or an in-bench model of the calibration math. Both channels idle at random, and the result side
// is held off once long enough to back the block up.
// ----------------------------------------------------------------------------
module magnetometer_minmax_calibration_tb;

    import mmcal_pkg::*;

    localparam int     FRAC       = 16;          // scale fraction bits
    localparam longint GAIN_ONE   = 65536;
    localparam longint GAIN_MAX   = 64'hFFFF_FFFF;
    localparam int     IDLE_LIMIT = 2000;        // cycles with no transfer at all
    localparam int     DRAIN_WAIT = 160;         // longest finalize plus margin
    localparam int     HOLD_LEN   = 300;         // long result-side hold-off
    localparam int     RAND_ITEMS = 500;

    typedef struct packed {
        logic [AXES-1:0][OUT_W-1:0] axis_out;
        logic                       calibrated;
        logic [COL_W-1:0]           collected;
        logic                       no_samples;
    } mag_result_t;

    typedef struct {
        logic [REQ_W-1:0] kind;
        logic [15:0]      sx;
        logic [15:0]      sy;
        logic [15:0]      sz;
        bit               fixed;
        mag_result_t      want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    mmcal_req_if #(.SAMPLE_BITS(16)) req_ch ();
    mmcal_res_if                     res_ch ();

    magnetometer_minmax_calibration dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    // model state of the calibration
    int     cal_lo [AXES];
    int     cal_hi [AXES];
    int     cal_off [AXES];
    longint cal_gain [AXES];
    int     cal_count;
    bit     cal_done;

    mag_result_t pending_results [$];

    // values of the request on the bus, set by the driver at the falling edge
    bit          cur_fixed;
    mag_result_t cur_want;

    bit burst;                   // no idling on either side while set
    int hold_cycles;             // one-shot long hold-off for the result side
    int errors;
    int results_seen;
    int items_sent;
    int n_kind [4];

    stim_row_t dir_tab [24];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------------
    // calibration model
    // ------------------------------------------------------------------------

    function automatic void clear_calib();
        for (int i = 0; i < AXES; i++)
        begin
            cal_lo[i]   = 32767;
            cal_hi[i]   = -32768;
            cal_off[i]  = 0;
            cal_gain[i] = GAIN_ONE;
        end
        cal_count = 0;
        cal_done  = 1'b0;
    endfunction

    function automatic mag_result_t calib_step(logic [REQ_W-1:0] kind,
                                               logic signed [15:0] sx,
                                               logic signed [15:0] sy,
                                               logic signed [15:0] sz);
        mag_result_t r;
        int          v [AXES];
        longint      span [AXES];
        longint      total;
        longint      mean;
        longint      q;
        r     = '0;
        total = 0;
        v[0]  = sx;
        v[1]  = sy;
        v[2]  = sz;
        case (kind)
            REQ_RESTART:
            begin
                clear_calib();
            end
            REQ_COLLECT:
            begin
                for (int i = 0; i < AXES; i++)
                begin
                    if (v[i] < cal_lo[i])
                        cal_lo[i] = v[i];
                    if (v[i] > cal_hi[i])
                        cal_hi[i] = v[i];
                end
                if (cal_count < COL_MAX)
                    cal_count++;
            end
            REQ_FINALIZE:
            begin
                if (cal_count == 0)
                begin
                    // nothing collected: keep offsets, scales and the done flag
                    r.no_samples = 1'b1;
                end
                else
                begin
                    for (int i = 0; i < AXES; i++)
                    begin
                        // arithmetic shift gives the floor of the midpoint
                        cal_off[i] = int'((longint'(cal_hi[i]) + cal_lo[i]) >>> 1);
                        span[i]    = longint'(cal_hi[i]) - cal_lo[i];
                        if (span[i] < 0)
                            span[i] = 0;
                        total += span[i];
                    end
                    mean = (total + 1) / 3;
                    for (int i = 0; i < AXES; i++)
                    begin
                        if (span[i] == 0)
                        begin
                            cal_gain[i] = GAIN_ONE;
                        end
                        else
                        begin
                            q = ((mean << FRAC) + span[i] / 2) / span[i];
                            cal_gain[i] = (q > GAIN_MAX) ? GAIN_MAX : q;
                        end
                    end
                    cal_done = 1'b1;
                end
            end
            REQ_CORRECT:
            begin
                for (int i = 0; i < AXES; i++)
                begin
                    q = ((longint'(v[i]) - cal_off[i]) * cal_gain[i]) >>> FRAC;
                    if (q > OUT_MAX)
                        q = OUT_MAX;
                    if (q < OUT_MIN)
                        q = OUT_MIN;
                    r.axis_out[i] = OUT_W'(q);
                end
            end
        endcase
        r.calibrated = cal_done;
        r.collected  = COL_W'(cal_count);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // table helpers
    // ------------------------------------------------------------------------

    function automatic mag_result_t result_of(int x, int y, int z, bit cal, int coll,
                                              bit nos);
        mag_result_t r;
        r.axis_out[0] = OUT_W'(x);
        r.axis_out[1] = OUT_W'(y);
        r.axis_out[2] = OUT_W'(z);
        r.calibrated  = cal;
        r.collected   = COL_W'(coll);
        r.no_samples  = nos;
        return r;
    endfunction

    // row whose result is typed in
    function automatic stim_row_t row_fix(logic [REQ_W-1:0] kind, int x, int y, int z,
                                          mag_result_t want);
        stim_row_t s;
        s.kind  = kind;
        s.sx    = 16'(x);
        s.sy    = 16'(y);
        s.sz    = 16'(z);
        s.fixed = 1'b1;
        s.want  = want;
        return s;
    endfunction

    // row checked against the model
    function automatic stim_row_t row_prd(logic [REQ_W-1:0] kind, int x, int y, int z);
        stim_row_t s;
        s.kind  = kind;
        s.sx    = 16'(x);
        s.sy    = 16'(y);
        s.sz    = 16'(z);
        s.fixed = 1'b0;
        s.want  = '0;
        return s;
    endfunction

    function automatic logic [15:0] rand16();
        return 16'($urandom);
    endfunction

    // sample within spread of a center, clipped to the 16-bit range
    function automatic logic [15:0] near(int c, int spread);
        int v;
        v = c + int'($urandom_range(0, 2 * spread)) - spread;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return 16'(v);
    endfunction

    task automatic report_mismatch(string msg);
        if (errors < 100)
            $display("mismatch: %s", msg);
        errors++;
    endtask

    // ------------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------------

    task automatic send_req(logic [REQ_W-1:0] kind, logic [15:0] sx, logic [15:0] sy,
                            logic [15:0] sz, bit fixed, mag_result_t want);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.sample_x <= sx;
        req_ch.sample_y <= sy;
        req_ch.sample_z <= sz;
        cur_fixed = fixed;
        cur_want  = want;
        do
            @(posedge clk);
        while (!req_ch.ready);
        items_sent++;
    endtask

    task automatic send_rand(logic [REQ_W-1:0] kind, logic [15:0] sx, logic [15:0] sy,
                             logic [15:0] sz);
        send_req(kind, sx, sy, sz, 1'b0, '0);
    endtask

    // sender pause: drop valid and wait for every pending result
    task automatic drain();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // result side: random stalls, plus the one long hold-off
    // ------------------------------------------------------------------------

    initial
    begin
        int stall;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = burst ? 0 : $urandom_range(0, 16);
            if (hold_cycles > 0)
            begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end
            if (stall > 0)
            begin
                @(negedge clk);
                res_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: model on each request transfer, compare on each result transfer
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        mag_result_t r;
        mag_result_t got;
        mag_result_t want;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                // the model always steps so its state tracks the block
                r = calib_step(req_ch.req_type, req_ch.sample_x, req_ch.sample_y,
                               req_ch.sample_z);
                pending_results.push_back(cur_fixed ? cur_want : r);
                n_kind[req_ch.req_type]++;
            end
            if (res_ch.valid && res_ch.ready)
            begin
                got.axis_out[0] = res_ch.out_x;
                got.axis_out[1] = res_ch.out_y;
                got.axis_out[2] = res_ch.out_z;
                got.calibrated  = res_ch.calibrated;
                got.collected   = res_ch.collected;
                got.no_samples  = res_ch.no_samples;
                if (pending_results.size() == 0)
                begin
                    report_mismatch("result transfer with nothing pending");
                end
                else
                begin
                    want = pending_results.pop_front();
                    for (int i = 0; i < AXES; i++)
                        if (got.axis_out[i] !== want.axis_out[i])
                            report_mismatch($sformatf("result %0d axis %0d: got %0d want %0d",
                                results_seen, i, $signed(got.axis_out[i]),
                                $signed(want.axis_out[i])));
                    if (got.calibrated !== want.calibrated)
                        report_mismatch($sformatf("result %0d calibrated: got %b want %b",
                            results_seen, got.calibrated, want.calibrated));
                    if (got.collected !== want.collected)
                        report_mismatch($sformatf("result %0d collected: got %0d want %0d",
                            results_seen, got.collected, want.collected));
                    if (got.no_samples !== want.no_samples)
                        report_mismatch($sformatf("result %0d no_samples: got %b want %b",
                            results_seen, got.no_samples, want.no_samples));
                end
                results_seen++;
            end
        end
    end

    // watchdog: too long without any transfer on either channel
    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT)
                break;
        end
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    initial
    begin
        int base;
        int pick;
        int n;
        int c [AXES];
        int spread [AXES];
        bit first;

        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_RESTART;
        req_ch.sample_x = '0;
        req_ch.sample_y = '0;
        req_ch.sample_z = '0;
        cur_fixed       = 1'b0;
        cur_want        = '0;
        burst           = 1'b0;
        hold_cycles     = 0;
        errors          = 0;
        results_seen    = 0;
        items_sent      = 0;
        n_kind          = '{0, 0, 0, 0};
        clear_calib();

        // directed table: extremes, restart, empty finalize, zero span,
        // repeated finalize, saturating correct, correct before calibration
        dir_tab = '{
            // reset state passes the raw sample through
            row_fix(REQ_CORRECT,  32767, -32768, 0, result_of(32767, -32768, 0, 0, 0, 0)),
            // finalize with nothing collected
            row_fix(REQ_FINALIZE, 0, 0, 0,           result_of(0, 0, 0, 0, 0, 1)),
            row_fix(REQ_COLLECT,  -32768, 32767, 0,  result_of(0, 0, 0, 0, 1, 0)),
            row_fix(REQ_COLLECT,  32767, -32768, 0,  result_of(0, 0, 0, 0, 2, 0)),
            // full span on x and y, zero span on z
            row_prd(REQ_FINALIZE, 1, 2, 3),
            row_prd(REQ_CORRECT,  32767, -32768, 5),
            row_prd(REQ_CORRECT,  -1, 0, -32768),
            row_fix(REQ_RESTART,  -1, -1, -1,        result_of(0, 0, 0, 0, 0, 0)),
            row_fix(REQ_CORRECT,  -2, 3, -4,         result_of(-2, 3, -4, 0, 0, 0)),
            // single sample: zero span everywhere
            row_fix(REQ_COLLECT,  0, 0, 0,           result_of(0, 0, 0, 0, 1, 0)),
            row_prd(REQ_FINALIZE, 0, 0, 0),
            row_prd(REQ_CORRECT,  -32768, 32767, 1234),
            row_prd(REQ_FINALIZE, -32768, -32768, -32768),
            row_fix(REQ_RESTART,  32767, 32767, 32767, result_of(0, 0, 0, 0, 0, 0)),
            // one-count span on x against full span on z: huge x gain
            row_fix(REQ_COLLECT,  100, 0, -32768,    result_of(0, 0, 0, 0, 1, 0)),
            row_fix(REQ_COLLECT,  101, 0, 32767,     result_of(0, 0, 0, 0, 2, 0)),
            row_prd(REQ_FINALIZE, 7, 7, 7),
            row_prd(REQ_CORRECT,  32767, 5, -32768),
            row_prd(REQ_CORRECT,  -32768, -5, 32767),
            // collect after calibration keeps the flag
            row_prd(REQ_COLLECT,  -1, -1, -1),
            row_prd(REQ_CORRECT,  0, 0, 0),
            row_prd(REQ_FINALIZE, 0, 0, 0),
            row_fix(REQ_RESTART,  0, 0, 0,           result_of(0, 0, 0, 0, 0, 0)),
            row_fix(REQ_FINALIZE, -1, -1, -1,        result_of(0, 0, 0, 0, 0, 1))
        };

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[k])
            send_req(dir_tab[k].kind, dir_tab[k].sx, dir_tab[k].sy, dir_tab[k].sz,
                     dir_tab[k].fixed, dir_tab[k].want);
        drain();

        // random sequences: mostly well-formed calibrations, some noise
        base  = items_sent;
        first = 1'b1;
        while (items_sent - base < RAND_ITEMS)
        begin
            burst = first || ($urandom_range(0, 4) == 0);
            if (first)
                hold_cycles = HOLD_LEN;   // back up the block while requests keep coming
            pick = first ? 9 : $urandom_range(0, 9);
            if (pick == 0)
            begin
                // noise: any request, any sample
                n = $urandom_range(1, 6);
                repeat (n)
                    send_rand(2'($urandom), rand16(), rand16(), rand16());
            end
            else if (pick == 1)
            begin
                // broken sequence: finalize straight after restart
                send_rand(REQ_RESTART, rand16(), rand16(), rand16());
                send_rand(REQ_FINALIZE, rand16(), rand16(), rand16());
                send_rand(REQ_CORRECT, rand16(), rand16(), rand16());
            end
            else
            begin
                // restart is sometimes skipped so ranges keep accumulating
                if ($urandom_range(0, 3) != 0)
                    send_rand(REQ_RESTART, rand16(), rand16(), rand16());
                for (int i = 0; i < AXES; i++)
                begin
                    c[i]      = $signed(rand16());
                    spread[i] = (1 << $urandom_range(0, 15)) - 1;
                end
                n = $urandom_range(1, 12);
                repeat (n)
                    send_rand(REQ_COLLECT, near(c[0], spread[0]), near(c[1], spread[1]),
                              near(c[2], spread[2]));
                send_rand(REQ_FINALIZE, rand16(), rand16(), rand16());
                n = $urandom_range(1, 5);
                repeat (n)
                begin
                    if ($urandom_range(0, 1) == 0)
                        send_rand(REQ_CORRECT, near(c[0], 2 * spread[0] + 1),
                                  near(c[1], 2 * spread[1] + 1),
                                  near(c[2], 2 * spread[2] + 1));
                    else
                        send_rand(REQ_CORRECT, rand16(), rand16(), rand16());
                end
            end
            if ($urandom_range(0, 5) == 0)
                drain();
            first = 1'b0;
        end

        burst = 1'b0;
        drain();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        $display("covered %0d requests: %0d restart, %0d collect, %0d finalize, %0d correct",
                 items_sent, n_kind[REQ_RESTART], n_kind[REQ_COLLECT],
                 n_kind[REQ_FINALIZE], n_kind[REQ_CORRECT]);
        $display("%0d results compared under random and long result stalls, %0d mismatches",
                 results_seen, errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
rtl/mmcal_pkg.sv
rtl/mmcal_if.sv
rtl/magnetometer_minmax_calibration.sv
dv/magnetometer_minmax_calibration_tb.sv
